/* src/elu_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and exp lookup tables for the ELU activation block.
// Depends on nothing; used by elu_csr, elu_datapath and elu_activation.
package elu_pkg;

   // Data format
   localparam int DATA_WIDTH      = 16;
   localparam int FRAC_BITS       = 12;
   localparam int SCALE_WIDTH     = DATA_WIDTH - 1;
   localparam int EXP_TABLE_DEPTH = 256;

   // Exp argument split: u = -(sample * arg_scale) has 2*FRAC_BITS fraction bits
   localparam int TF            = 2 * FRAC_BITS;
   localparam int U_BITS        = 2 * DATA_WIDTH - 2;
   localparam int IDX_BITS      = $clog2(EXP_TABLE_DEPTH);
   localparam int W_BITS        = 16;
   localparam int INT_ENTRIES   = 17;
   localparam int INT_IDX_BITS  = $clog2(INT_ENTRIES);
   localparam int INT_TAB_SLOTS = 1 << INT_IDX_BITS;

   // Q1.30 table format
   localparam int Q_FRAC = 30;
   localparam int Q_BITS = Q_FRAC + 1;

   // Intermediate result widths
   localparam int PROD_BITS = 2 * DATA_WIDTH;
   localparam int YP_BITS   = PROD_BITS - FRAC_BITS;
   localparam int NP_BITS   = Q_BITS + 1 + DATA_WIDTH;
   localparam int YN_BITS   = NP_BITS - Q_FRAC;

   // Pipeline depth, output register included
   localparam int STAGES = 6;

   // Exp term is zero beyond this argument magnitude (16.0)
   localparam logic [U_BITS-1:0] DEEP_LIMIT = U_BITS'(16) << TF;

   // Register reset value: 1.0 in Q4.12
   localparam logic [DATA_WIDTH-1:0] COEF_ONE = DATA_WIDTH'(1 << FRAC_BITS);

   // Configuration port
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 2;
   localparam logic [REG_IDX_BITS-1:0] REG_NEG_COEF  = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_POS_COEF  = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_ARG_SCALE = 2'd2;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0]  neg_coef;
      logic signed [DATA_WIDTH-1:0]  pos_coef;
      logic        [SCALE_WIDTH-1:0] arg_scale;
   } coef_type;

   typedef logic [Q_BITS-1:0]                             q30_type;
   typedef logic [EXP_TABLE_DEPTH-1:0][Q_BITS-1:0]        frac_tab_type;
   typedef logic [INT_TAB_SLOTS-1:0][Q_BITS-1:0]          int_tab_type;

   // exp(-x) in Q1.30 for 0 <= x <= 1.0, alternating Taylor series of 21 terms
   function automatic q30_type exp_neg_q30(input logic [63:0] x);
      logic [63:0]        term;
      logic signed [63:0] sum;
      term = 64'd1 << Q_FRAC;
      sum  = 64'sd1 <<< Q_FRAC;
      for (int k = 1; k <= 20; k++) begin
         term = ((term * x) >> Q_FRAC) / 64'(k);
         if ((k % 2) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      return Q_BITS'(sum);
   endfunction

   // Fraction table exp(-k/DEPTH); offset 1 gives the next entry for interpolation
   function automatic frac_tab_type build_frac_tab(input int offset);
      frac_tab_type tab;
      logic [63:0]  x;
      for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
         x      = (64'(k + offset) << Q_FRAC) / 64'(EXP_TABLE_DEPTH);
         tab[k] = exp_neg_q30(x);
      end
      return tab;
   endfunction

   // Integer table exp(-n), n = 0..16; unused slots are zero
   function automatic int_tab_type build_int_tab();
      int_tab_type tab;
      logic [63:0] prod;
      tab    = '0;
      tab[0] = Q_BITS'(64'd1 << Q_FRAC);
      tab[1] = exp_neg_q30(64'd1 << Q_FRAC);
      for (int k = 2; k < INT_ENTRIES; k++) begin
         prod   = 64'(tab[k-1]) * 64'(tab[1]);
         tab[k] = Q_BITS'((prod + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC);
      end
      return tab;
   endfunction

   localparam frac_tab_type FRAC_LO_TAB = build_frac_tab(0);
   localparam frac_tab_type FRAC_HI_TAB = build_frac_tab(1);
   localparam int_tab_type  INT_TAB     = build_int_tab();

endpackage

/* src/elu_csr.sv */
`timescale 1ns / 1ps
// APB-style register file holding the ELU coefficients.
// Depends on elu_pkg for register codes, widths and the coef_type struct.
module elu_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [elu_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [elu_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [elu_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready,
   output elu_pkg::coef_type                    coef
);

   elu_pkg::coef_type                    coef_ff;
   elu_pkg::coef_type                    coef_in;
   logic [elu_pkg::REG_IDX_BITS-1:0]     reg_idx;
   logic                                 wr_en;

   assign reg_idx    = csr_paddr[elu_pkg::CSR_ADDR_BITS-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign coef       = coef_ff;

   // Write decode: low bits of the data word are kept
   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         unique case (reg_idx)
            elu_pkg::REG_NEG_COEF: begin
               coef_in.neg_coef = $signed(csr_pwdata[elu_pkg::DATA_WIDTH-1:0]);
            end
            elu_pkg::REG_POS_COEF: begin
               coef_in.pos_coef = $signed(csr_pwdata[elu_pkg::DATA_WIDTH-1:0]);
            end
            elu_pkg::REG_ARG_SCALE: begin
               coef_in.arg_scale = csr_pwdata[elu_pkg::SCALE_WIDTH-1:0];
            end
            default: begin
               coef_in = coef_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.neg_coef  <= $signed(elu_pkg::COEF_ONE);
         coef_ff.pos_coef  <= $signed(elu_pkg::COEF_ONE);
         coef_ff.arg_scale <= elu_pkg::COEF_ONE[elu_pkg::SCALE_WIDTH-1:0];
      end else begin
         coef_ff <= coef_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_idx)
         elu_pkg::REG_NEG_COEF: begin
            csr_prdata = elu_pkg::CSR_DATA_BITS'(unsigned'(coef_ff.neg_coef));
         end
         elu_pkg::REG_POS_COEF: begin
            csr_prdata = elu_pkg::CSR_DATA_BITS'(unsigned'(coef_ff.pos_coef));
         end
         elu_pkg::REG_ARG_SCALE: begin
            csr_prdata = elu_pkg::CSR_DATA_BITS'(coef_ff.arg_scale);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

endmodule

/* src/elu_datapath.sv */
`timescale 1ns / 1ps
// Six-stage ELU datapath: input multiply, table lookup, interpolation,
// exp assembly, coefficient multiply, round and saturate. Depends on elu_pkg.
module elu_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  elu_pkg::coef_type                     coef,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [elu_pkg::DATA_WIDTH-1:0] req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [elu_pkg::DATA_WIDTH-1:0] rsp_activation,
   output logic                                  rsp_saturated
);

   localparam int DW = elu_pkg::DATA_WIDTH;
   localparam int QB = elu_pkg::Q_BITS;

   // Pipeline control: a stage loads when it is empty or its successor moves
   logic [elu_pkg::STAGES-1:0] valid_ff;
   logic [elu_pkg::STAGES-1:0] valid_in;
   logic [elu_pkg::STAGES-1:0] advance;

   always_comb begin
      advance[elu_pkg::STAGES-1] = ~valid_ff[elu_pkg::STAGES-1] | ~rsp_stall;
      for (int k = elu_pkg::STAGES - 2; k >= 0; k--) begin
         advance[k] = ~valid_ff[k] | advance[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < elu_pkg::STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < elu_pkg::STAGES; k++) begin
            if (advance[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_stall = ~advance[0];
   assign rsp_valid = valid_ff[elu_pkg::STAGES-1];

   // Stage 1: both input products
   logic                                    pos1_ff, pos1_in;
   logic signed [elu_pkg::PROD_BITS-1:0]    t1_ff, t1_in;
   logic signed [elu_pkg::PROD_BITS-1:0]    p1_ff, p1_in;

   always_comb begin
      pos1_in = (req_sample > $signed(DW'(0)));
      t1_in   = req_sample * $signed({1'b0, coef.arg_scale});
      p1_in   = req_sample * coef.pos_coef;
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         pos1_ff <= pos1_in;
         t1_ff   <= t1_in;
         p1_ff   <= p1_in;
      end
   end

   // Stage 2: split exp argument, table reads, positive rounding
   logic [elu_pkg::U_BITS-1:0]              u2;
   logic [elu_pkg::INT_IDX_BITS-1:0]        n2;
   logic [elu_pkg::IDX_BITS-1:0]            idx2;
   logic                                    pos2_ff, pos2_in;
   logic                                    deep2_ff, deep2_in;
   logic [QB-1:0]                           flo2_ff, flo2_in;
   logic [QB-1:0]                           fhi2_ff, fhi2_in;
   logic [QB-1:0]                           eint2_ff, eint2_in;
   logic [elu_pkg::W_BITS-1:0]              w2_ff, w2_in;
   logic signed [elu_pkg::YP_BITS-1:0]      ypos2_ff, ypos2_in;

   always_comb begin
      u2       = elu_pkg::U_BITS'(-t1_ff);
      deep2_in = (u2 > elu_pkg::DEEP_LIMIT);
      n2       = u2[elu_pkg::TF +: elu_pkg::INT_IDX_BITS];
      idx2     = u2[elu_pkg::TF-1 -: elu_pkg::IDX_BITS];
      w2_in    = u2[elu_pkg::TF-elu_pkg::IDX_BITS-1 -: elu_pkg::W_BITS];
      flo2_in  = elu_pkg::FRAC_LO_TAB[idx2];
      fhi2_in  = elu_pkg::FRAC_HI_TAB[idx2];
      eint2_in = elu_pkg::INT_TAB[n2];
      pos2_in  = pos1_ff;
      ypos2_in = elu_pkg::YP_BITS'(
                    (p1_ff + $signed(elu_pkg::PROD_BITS'(1 << (elu_pkg::FRAC_BITS - 1))))
                    >>> elu_pkg::FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (advance[1]) begin
         pos2_ff  <= pos2_in;
         deep2_ff <= deep2_in;
         flo2_ff  <= flo2_in;
         fhi2_ff  <= fhi2_in;
         eint2_ff <= eint2_in;
         w2_ff    <= w2_in;
         ypos2_ff <= ypos2_in;
      end
   end

   // Stage 3: linear interpolation between fraction entries
   logic [QB-1:0]                           diff3;
   logic [QB+elu_pkg::W_BITS-1:0]           corr3;
   logic                                    pos3_ff, deep3_ff;
   logic [QB-1:0]                           fe3_ff, fe3_in;
   logic [QB-1:0]                           eint3_ff;
   logic signed [elu_pkg::YP_BITS-1:0]      ypos3_ff;

   always_comb begin
      diff3  = flo2_ff - fhi2_ff;
      corr3  = diff3 * w2_ff;
      fe3_in = flo2_ff - QB'(corr3 >> elu_pkg::W_BITS);
   end

   always_ff @(posedge clock) begin
      if (advance[2]) begin
         pos3_ff  <= pos2_ff;
         deep3_ff <= deep2_ff;
         fe3_ff   <= fe3_in;
         eint3_ff <= eint2_ff;
         ypos3_ff <= ypos2_ff;
      end
   end

   // Stage 4: exp = integer part times fraction part
   logic [2*QB-1:0]                         ep4;
   logic                                    pos4_ff;
   logic [QB-1:0]                           e4_ff, e4_in;
   logic signed [elu_pkg::YP_BITS-1:0]      ypos4_ff;

   always_comb begin
      ep4   = eint3_ff * fe3_ff;
      e4_in = deep3_ff ? '0 : QB'(ep4 >> elu_pkg::Q_FRAC);
   end

   always_ff @(posedge clock) begin
      if (advance[3]) begin
         pos4_ff  <= pos3_ff;
         e4_ff    <= e4_in;
         ypos4_ff <= ypos3_ff;
      end
   end

   // Stage 5: (exp - 1) times negative coefficient
   logic signed [QB:0]                      em1_5;
   logic                                    pos5_ff;
   logic signed [elu_pkg::NP_BITS-1:0]      np5_ff, np5_in;
   logic signed [elu_pkg::YP_BITS-1:0]      ypos5_ff;

   always_comb begin
      em1_5  = $signed({1'b0, e4_ff}) - $signed((QB+1)'(1 << elu_pkg::Q_FRAC));
      np5_in = em1_5 * coef.neg_coef;
   end

   always_ff @(posedge clock) begin
      if (advance[4]) begin
         pos5_ff  <= pos4_ff;
         np5_ff   <= np5_in;
         ypos5_ff <= ypos4_ff;
      end
   end

   // Stage 6: round, select branch, saturate into the output register
   logic signed [elu_pkg::YN_BITS-1:0]      yneg6;
   logic signed [elu_pkg::YP_BITS-1:0]      y6;
   logic signed [elu_pkg::YP_BITS-1:0]      hi6, lo6;
   logic signed [DW-1:0]                    act6_ff, act6_in;
   logic                                    sat6_ff, sat6_in;

   always_comb begin
      yneg6 = elu_pkg::YN_BITS'(
                 (np5_ff + $signed(elu_pkg::NP_BITS'(1 << (elu_pkg::Q_FRAC - 1))))
                 >>> elu_pkg::Q_FRAC);
      y6  = pos5_ff ? ypos5_ff : elu_pkg::YP_BITS'(yneg6);
      hi6 = $signed(elu_pkg::YP_BITS'((1 << (DW - 1)) - 1));
      lo6 = -hi6 - $signed(elu_pkg::YP_BITS'(1));
      if (y6 > hi6) begin
         act6_in = DW'(hi6);
         sat6_in = 1'b1;
      end else if (y6 < lo6) begin
         act6_in = DW'(lo6);
         sat6_in = 1'b1;
      end else begin
         act6_in = DW'(y6);
         sat6_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance[5]) begin
         act6_ff <= act6_in;
         sat6_ff <= sat6_in;
      end
   end

   assign rsp_activation = act6_ff;
   assign rsp_saturated  = sat6_ff;

endmodule

/* src/elu_activation.sv */
`timescale 1ns / 1ps
// Top level of the ELU/SELU/CELU activation block: register file and datapath.
// Depends on elu_pkg, elu_csr and elu_datapath.

// One signed Q4.12 sample goes in per item and one activation plus a saturation
// flag comes out, in order. One item is taken every cycle unless a result stall
// backs up to the input. Stages: input multiply, exp table lookup, interpolation,
// exp product, coefficient multiply, round and saturate (the output register). A
// result stall holds each full stage while empty stages keep filling, so no item
// is lost or repeated. The exp tables are constant logic; there is no clearing
// pass after reset. The user writes coefficients through the register port while
// no item is in flight; the block itself does not enforce this.
module elu_activation (
   input  logic                                  clock,
   input  logic                                  reset,
   // input items
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [elu_pkg::DATA_WIDTH-1:0] req_sample,
   // result items
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [elu_pkg::DATA_WIDTH-1:0] rsp_activation,
   output logic                                  rsp_saturated,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [elu_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [elu_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [elu_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   elu_pkg::coef_type coef;

   // Coefficient registers
   elu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   // Activation pipeline
   elu_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .coef           (coef),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_activation (rsp_activation),
      .rsp_saturated  (rsp_saturated)
   );

endmodule
